@@ src/klex_pkg.sv @@
package klex_pkg;

  // queue depth between stages; pointers wrap by truncation, keep it a power of two
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // automaton states; values below ST_KW_END are keyword_index*8 + chars_matched
  localparam logic [6:0] ST_START  = 7'd0;
  localparam logic [6:0] ST_KW_END = 7'd104;
  localparam logic [6:0] ST_LPAR   = 7'd104;
  localparam logic [6:0] ST_RPAR   = 7'd105;
  localparam logic [6:0] ST_COMMA  = 7'd106;
  localparam logic [6:0] ST_SEMI   = 7'd107;
  localparam logic [6:0] ST_LBR    = 7'd108;
  localparam logic [6:0] ST_RBR    = 7'd109;
  localparam logic [6:0] ST_PLUS   = 7'd110;
  localparam logic [6:0] ST_MINUS  = 7'd111;
  localparam logic [6:0] ST_STAR   = 7'd112;
  localparam logic [6:0] ST_LTGT   = 7'd113;
  localparam logic [6:0] ST_LE     = 7'd114;
  localparam logic [6:0] ST_GE     = 7'd115;
  localparam logic [6:0] ST_EQEQ   = 7'd116;
  localparam logic [6:0] ST_SLASH  = 7'd117;
  localparam logic [6:0] ST_LT     = 7'd118;
  localparam logic [6:0] ST_GT     = 7'd119;
  localparam logic [6:0] ST_EQ     = 7'd120;
  localparam logic [6:0] ST_CBODY  = 7'd121;
  localparam logic [6:0] ST_CSTAR  = 7'd122;
  localparam logic [6:0] ST_CEND   = 7'd123;
  localparam logic [6:0] ST_NUM    = 7'd124;
  localparam logic [6:0] ST_IDENT  = 7'd125;

  localparam logic [3:0] NUM_KW = 4'd12;

  // token codes
  localparam logic [5:0] CODE_FALSE   = 6'd0;
  localparam logic [5:0] CODE_TRUE    = 6'd1;
  localparam logic [5:0] CODE_ERROR   = 6'd2;
  localparam logic [5:0] CODE_BOOL    = 6'd3;
  localparam logic [5:0] CODE_INT     = 6'd4;
  localparam logic [5:0] CODE_VOID    = 6'd5;
  localparam logic [5:0] CODE_SEMIC   = 6'd6;
  localparam logic [5:0] CODE_PRINT   = 6'd7;
  localparam logic [5:0] CODE_PROC    = 6'd8;
  localparam logic [5:0] CODE_IF      = 6'd9;
  localparam logic [5:0] CODE_ELSE    = 6'd10;
  localparam logic [5:0] CODE_WHILE   = 6'd11;
  localparam logic [5:0] CODE_DO      = 6'd12;
  localparam logic [5:0] CODE_LPAR    = 6'd13;
  localparam logic [5:0] CODE_RPAR    = 6'd14;
  localparam logic [5:0] CODE_COMMA   = 6'd15;
  localparam logic [5:0] CODE_SEMI    = 6'd16;
  localparam logic [5:0] CODE_LBR     = 6'd17;
  localparam logic [5:0] CODE_RBR     = 6'd18;
  localparam logic [5:0] CODE_ASSIGN  = 6'd19;
  localparam logic [5:0] CODE_PLUS    = 6'd20;
  localparam logic [5:0] CODE_MINUS   = 6'd21;
  localparam logic [5:0] CODE_STAR    = 6'd22;
  localparam logic [5:0] CODE_SLASH   = 6'd23;
  localparam logic [5:0] CODE_EQEQ    = 6'd24;
  localparam logic [5:0] CODE_NE      = 6'd25;
  localparam logic [5:0] CODE_GT      = 6'd26;
  localparam logic [5:0] CODE_GE      = 6'd27;
  localparam logic [5:0] CODE_LT      = 6'd28;
  localparam logic [5:0] CODE_LE      = 6'd29;
  localparam logic [5:0] CODE_IDENT   = 6'd30;
  localparam logic [5:0] CODE_NUMBER  = 6'd31;
  localparam logic [5:0] CODE_COMMENT = 6'd32;

  typedef struct packed {
    logic letter;
    logic digit;
    logic space;
    logic ccommon;   // allowed anywhere in a comment body
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    cls_t       cls;
  } item_t;

  typedef struct packed {
    logic       is_attr;
    logic [5:0] code;
    logic [7:0] attr;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] state;
  } kw_adv_t;

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] l;
    case (k)
      4'd0:    l = 3'd5;
      4'd1:    l = 3'd4;
      4'd2:    l = 3'd4;
      4'd3:    l = 3'd3;
      4'd4:    l = 3'd4;
      4'd5:    l = 3'd5;
      4'd6:    l = 3'd5;
      4'd7:    l = 3'd4;
      4'd8:    l = 3'd2;
      4'd9:    l = 3'd4;
      4'd10:   l = 3'd5;
      4'd11:   l = 3'd2;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [5:0] kw_code(input logic [3:0] k);
    logic [5:0] c;
    case (k)
      4'd0:    c = CODE_FALSE;
      4'd1:    c = CODE_TRUE;
      4'd2:    c = CODE_BOOL;
      4'd3:    c = CODE_INT;
      4'd4:    c = CODE_VOID;
      4'd5:    c = CODE_SEMIC;
      4'd6:    c = CODE_PRINT;
      4'd7:    c = CODE_PROC;
      4'd8:    c = CODE_IF;
      4'd9:    c = CODE_ELSE;
      4'd10:   c = CODE_WHILE;
      4'd11:   c = CODE_DO;
      default: c = CODE_ERROR;
    endcase
    return c;
  endfunction

  // character p of keyword k, 0 past its end
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [39:0] s;
    logic [2:0]  l;
    int          idx;
    logic [7:0]  r;
    case (k)
      4'd0:    s = 40'("false");
      4'd1:    s = 40'("true");
      4'd2:    s = 40'("bool");
      4'd3:    s = 40'("int");
      4'd4:    s = 40'("void");
      4'd5:    s = 40'("semic");
      4'd6:    s = 40'("print");
      4'd7:    s = 40'("proc");
      4'd8:    s = 40'("if");
      4'd9:    s = 40'("else");
      4'd10:   s = 40'("while");
      4'd11:   s = 40'("do");
      default: s = '0;
    endcase
    l   = kw_len(k);
    idx = 0;
    r   = 8'h00;
    if (p < l) begin
      // literal is right justified: first char sits in the top used byte
      idx = int'(l) - 1 - int'(p);
      r   = s[8*idx +: 8];
    end
    return r;
  endfunction

  // lowest keyword sharing the first pos chars of keyword k whose next char is c
  function automatic kw_adv_t kw_advance(input logic [3:0] k, input logic [2:0] pos,
                                         input logic [7:0] c);
    kw_adv_t r;
    logic    eq;
    r = '0;
    for (int j = 11; j >= 0; j--) begin
      eq = (kw_len(4'(j)) > pos);
      for (int i = 0; i < 5; i++) begin
        if (3'(i) < pos && kw_char(4'(j), 3'(i)) != kw_char(k, 3'(i))) begin
          eq = 1'b0;
        end
      end
      if (eq && kw_char(4'(j), pos) == c) begin
        r.hit   = 1'b1;
        r.state = {4'(j), 3'(pos + 3'd1)};
      end
    end
    return r;
  endfunction

  // code given by the closing space in the plain await-space states
  function automatic logic [5:0] await_code(input logic [6:0] s);
    logic [5:0] c;
    case (s)
      ST_LPAR:  c = CODE_LPAR;
      ST_RPAR:  c = CODE_RPAR;
      ST_COMMA: c = CODE_COMMA;
      ST_SEMI:  c = CODE_SEMI;
      ST_LBR:   c = CODE_LBR;
      ST_RBR:   c = CODE_RBR;
      ST_PLUS:  c = CODE_PLUS;
      ST_MINUS: c = CODE_MINUS;
      ST_STAR:  c = CODE_STAR;
      ST_LTGT:  c = CODE_NE;
      ST_LE:    c = CODE_LE;
      ST_GE:    c = CODE_GE;
      ST_EQEQ:  c = CODE_EQEQ;
      default:  c = CODE_ERROR;
    endcase
    return c;
  endfunction

endpackage

@@ src/klex_front.sv @@
module klex_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           char_in_i,
  output logic                 item_valid_o,
  output klex_pkg::item_t      item_o,
  input  logic                 item_pop_i
);

  klex_pkg::item_t              mem_q [klex_pkg::QDEPTH];
  logic [klex_pkg::QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [klex_pkg::QAW:0]       cnt_q;
  klex_pkg::cls_t               cls;
  logic                         do_push, do_pop;

  always_comb begin
    cls.letter  = (char_in_i >= "a" && char_in_i <= "z") ||
                  (char_in_i >= "A" && char_in_i <= "Z");
    cls.digit   = (char_in_i >= "0" && char_in_i <= "9");
    cls.space   = (char_in_i == " ");
    cls.ccommon = cls.letter || cls.digit ||
                  (char_in_i inside {"_", "}", "{", ";", ",", "(", ")", "=", ">", "<",
                                     "-", "+", " "});
  end

  assign full         = (cnt_q == (klex_pkg::QAW+1)'(klex_pkg::QDEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= '{ch: char_in_i, cls: cls};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/klex_back.sv @@
module klex_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  klex_pkg::item_t      item_i,
  output logic                 item_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output klex_pkg::result_t    res_o
);

  logic [6:0]                   st_q, st_d;
  logic                         skip_q, skip_d;
  klex_pkg::result_t            res;
  logic                         res_v;
  logic                         step;
  klex_pkg::result_t            mem_q [klex_pkg::QDEPTH];
  logic [klex_pkg::QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [klex_pkg::QAW:0]       cnt_q;
  logic                         out_full, do_push, do_pop;

  assign out_full   = (cnt_q == (klex_pkg::QAW+1)'(klex_pkg::QDEPTH));
  assign step       = item_valid_i && !out_full;
  assign item_pop_o = step;

  // one automaton transition per character
  always_comb begin
    logic               do_fail, do_fin;
    logic [5:0]         fin_code;
    klex_pkg::kw_adv_t  adv;
    logic [3:0]         k;
    logic [2:0]         pos;
    logic [7:0]         ch;
    klex_pkg::cls_t     cls;

    ch       = item_i.ch;
    cls      = item_i.cls;
    k        = st_q[6:3];
    pos      = st_q[2:0];
    do_fail  = 1'b0;
    do_fin   = 1'b0;
    fin_code = '0;
    adv      = '0;
    res      = '0;
    res_v    = 1'b0;
    st_d     = st_q;
    skip_d   = skip_q;

    if (skip_q) begin
      if (cls.space) begin
        skip_d = 1'b0;
        st_d   = klex_pkg::ST_START;
      end
    end else if (st_q == klex_pkg::ST_START) begin
      case (ch)
        "(": st_d = klex_pkg::ST_LPAR;
        ")": st_d = klex_pkg::ST_RPAR;
        ",": st_d = klex_pkg::ST_COMMA;
        ";": st_d = klex_pkg::ST_SEMI;
        "{": st_d = klex_pkg::ST_LBR;
        "}": st_d = klex_pkg::ST_RBR;
        "+": st_d = klex_pkg::ST_PLUS;
        "-": st_d = klex_pkg::ST_MINUS;
        "*": st_d = klex_pkg::ST_STAR;
        "/": st_d = klex_pkg::ST_SLASH;
        "<": st_d = klex_pkg::ST_LT;
        ">": st_d = klex_pkg::ST_GT;
        "=": st_d = klex_pkg::ST_EQ;
        "_": st_d = klex_pkg::ST_IDENT;
        default: begin
          if (cls.digit) begin
            st_d        = klex_pkg::ST_NUM;
            res_v       = 1'b1;
            res.is_attr = 1'b1;
            res.attr    = ch;
          end else begin
            adv = klex_pkg::kw_advance(4'd0, 3'd0, ch);
            if (adv.hit) st_d = adv.state;
            else do_fail = 1'b1;
          end
        end
      endcase
    end else if (st_q < klex_pkg::ST_KW_END) begin
      if (k >= klex_pkg::NUM_KW || pos == 3'd0 || pos > klex_pkg::kw_len(k)) begin
        do_fail = 1'b1;
      end else if (pos == klex_pkg::kw_len(k)) begin
        do_fin   = 1'b1;
        fin_code = klex_pkg::kw_code(k);
      end else begin
        adv = klex_pkg::kw_advance(k, pos, ch);
        if (adv.hit) st_d = adv.state;
        else do_fail = 1'b1;
      end
    end else if (st_q <= klex_pkg::ST_EQEQ) begin
      do_fin   = 1'b1;
      fin_code = klex_pkg::await_code(st_q);
    end else begin
      case (st_q)
        klex_pkg::ST_SLASH: begin
          if (ch == "*") st_d = klex_pkg::ST_CBODY;
          else begin
            do_fin   = 1'b1;
            fin_code = klex_pkg::CODE_SLASH;
          end
        end
        klex_pkg::ST_LT: begin
          if (ch == ">") st_d = klex_pkg::ST_LTGT;
          else if (ch == "=") st_d = klex_pkg::ST_LE;
          else begin
            do_fin   = 1'b1;
            fin_code = klex_pkg::CODE_LT;
          end
        end
        klex_pkg::ST_GT: begin
          if (ch == "=") st_d = klex_pkg::ST_GE;
          else begin
            do_fin   = 1'b1;
            fin_code = klex_pkg::CODE_GT;
          end
        end
        klex_pkg::ST_EQ: begin
          if (ch == "=") st_d = klex_pkg::ST_EQEQ;
          else begin
            do_fin   = 1'b1;
            fin_code = klex_pkg::CODE_ASSIGN;
          end
        end
        klex_pkg::ST_CBODY: begin
          if (cls.ccommon || ch == "/") st_d = st_q;
          else if (ch == "*") st_d = klex_pkg::ST_CSTAR;
          else do_fail = 1'b1;
        end
        klex_pkg::ST_CSTAR: begin
          if (cls.ccommon || ch == "*") st_d = st_q;
          else if (ch == "/") st_d = klex_pkg::ST_CEND;
          else do_fail = 1'b1;
        end
        klex_pkg::ST_CEND: begin
          do_fin   = 1'b1;
          fin_code = klex_pkg::CODE_COMMENT;
        end
        klex_pkg::ST_NUM: begin
          if (cls.digit) begin
            res_v       = 1'b1;
            res.is_attr = 1'b1;
            res.attr    = ch;
          end else begin
            do_fin   = 1'b1;
            fin_code = klex_pkg::CODE_NUMBER;
          end
        end
        klex_pkg::ST_IDENT: begin
          if (cls.letter) begin
            res_v       = 1'b1;
            res.is_attr = 1'b1;
            res.attr    = ch;
          end else begin
            do_fin   = 1'b1;
            fin_code = klex_pkg::CODE_IDENT;
          end
        end
        default: do_fail = 1'b1;
      endcase
    end

    // a token only closes on a space
    if (do_fin && !cls.space) do_fail = 1'b1;

    if (do_fail) begin
      st_d     = klex_pkg::ST_START;
      skip_d   = !cls.space;
      res_v    = 1'b1;
      res      = '0;
      res.code = klex_pkg::CODE_ERROR;
    end else if (do_fin) begin
      st_d     = klex_pkg::ST_START;
      res_v    = 1'b1;
      res      = '0;
      res.code = fin_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= klex_pkg::ST_START;
      skip_q <= 1'b0;
    end else if (step) begin
      st_q   <= st_d;
      skip_q <= skip_d;
    end
  end

  // result queue
  assign do_push = step && res_v;
  assign empty   = (cnt_q == '0);
  assign do_pop  = pop && !empty;
  assign res_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/keyword_token_lexer_unit.sv @@
// channel   direction  handshake           payload
// input     in         push / full         char_in_i
// result    out        empty / pop         is_attribute_o, token_code_o, attr_char_o
//
// One character per cycle sustained while the result side keeps up; a character's result,
// if it gives one, passes the input queue and then one automaton step, which writes it into
// the result queue, from where it can be popped.
// The state update is the single rate-setting loop: one transition a cycle unless stalled.
// Reset is asynchronous: both queues empty, automaton at its start state, skip flag clear.
// A stalled result side fills the result queue, then the input queue, then raises full.
module keyword_token_lexer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  output logic       empty,
  input  logic       pop,
  output logic       is_attribute_o,
  output logic [5:0] token_code_o,
  output logic [7:0] attr_char_o
);

  logic               item_valid;
  logic               item_pop;
  klex_pkg::item_t    item;
  klex_pkg::result_t  res;

  klex_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .char_in_i    (char_in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  klex_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign is_attribute_o = res.is_attr;
  assign token_code_o   = res.code;
  assign attr_char_o    = res.attr;

endmodule
